### hdl/dip_pkg.sv
`default_nettype none
package dip_pkg;

  localparam int unsigned FracW = 52;
  localparam int unsigned SigW  = 53;
  localparam int unsigned ExpW  = 11;
  localparam int unsigned ProdW = 106;
  localparam int unsigned TexpW = 14;
  localparam int unsigned QuoW  = 56;

  localparam logic [63:0]        ONE_BITS   = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0]        POS_ZERO   = 64'h0;
  localparam logic [63:0]        DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [ExpW-1:0]    EXP_MAX    = 11'h7FF;
  localparam logic [63:0]        QUIET_BIT  = 64'h0008_0000_0000_0000;

  // value = w * 2^texp with w normalised at bit ProdW-1 gives biased exp texp + RndOfs
  localparam logic signed [TexpW-1:0] RND_OFS = 14'sd1128;
  localparam logic signed [TexpW-1:0] MUL_OFS = 14'sd2150;
  localparam logic signed [TexpW-1:0] DIV_OFS = 14'sd918;

  function automatic logic is_nan(input logic [63:0] v);
    return (v[62:52] == EXP_MAX) && (v[51:0] != '0);
  endfunction

  function automatic logic is_inf(input logic [63:0] v);
    return (v[62:52] == EXP_MAX) && (v[51:0] == '0);
  endfunction

  function automatic logic is_zero(input logic [63:0] v);
    return v[62:0] == '0;
  endfunction

  function automatic logic [SigW-1:0] sig_of(input logic [63:0] v);
    return {(v[62:52] != '0), v[51:0]};
  endfunction

  // biased exponent, subnormals count as one
  function automatic logic signed [TexpW-1:0] exp_of(input logic [63:0] v);
    return (v[62:52] == '0) ? 14'sd1 : $signed({3'b000, v[62:52]});
  endfunction

endpackage
`default_nettype wire

### hdl/double_integer_power.sv
// channel  | direction | signals
// ---------+-----------+---------------------------------------------------
// input    | in        | in_valid_i, in_ready_o, base_bits_i, exponent_i
// output   | out       | out_valid_o, out_ready_i, power_bits_o
//
// one item at a time; a multiply is a set-up step, shift-add steps over the
// multiplier, normalise and round and a check step; a reciprocal is a
// restoring division; multiplies follow the exponent and stop early on zero,
// one, a fixed point or a product that alternates between two values.
// reset clears the sequencer and the output slot; the next item is taken
// while a finished result still waits for out_ready_i.
`default_nettype none
module double_integer_power (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] base_bits_i,
  input  wire logic signed [31:0] exponent_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      power_bits_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RSTART, S_RNORM, S_RDIV, S_START, S_MSTART, S_MUL,
    S_NORM, S_DENORM, S_ROUND, S_CHECK, S_FIN
  } state_e;

  localparam int unsigned PW = dip_pkg::ProdW;
  localparam int unsigned TW = dip_pkg::TexpW;

  state_e state_q, state_d;
  logic [63:0] base_q, base_d, x_q, x_d, prev_q, prev_d, y_q, y_d, res_q, res_d;
  logic have_prev_q, have_prev_d, recip_q, recip_d;
  logic [31:0] mag_q, mag_d, left_q, left_d;
  logic [PW-1:0] w_q, w_d, mcand_q, mcand_d;
  logic [dip_pkg::SigW-1:0] mplier_q, mplier_d, dvs_q, dvs_d;
  logic [dip_pkg::SigW+1:0] rem_q, rem_d;
  logic sticky_q, sticky_d, sign_q, sign_d;
  logic signed [TW-1:0] texp_q, texp_d;
  logic [5:0] cnt_q, cnt_d;
  logic [63:0] out_q, out_d;
  logic out_valid_q, out_valid_d;

  // combinational helpers
  logic [31:0] left_nx;
  logic signed [TW-1:0] ebias;
  logic [dip_pkg::SigW-1:0] r53;
  logic [dip_pkg::SigW:0] rsum;
  logic rinc;
  logic signed [TW-1:0] efin;
  logic [dip_pkg::SigW-1:0] rfin;
  logic [63:0] packed_res;
  logic [dip_pkg::SigW+1:0] rem_sub;
  logic rem_ge;

  assign left_nx = left_q - 32'd1;
  assign ebias   = texp_q + dip_pkg::RND_OFS;

  always_comb begin
    r53  = w_q[PW-1 -: dip_pkg::SigW];
    rinc = w_q[PW-1-dip_pkg::SigW] &
           ((|w_q[PW-2-dip_pkg::SigW:0]) | sticky_q | r53[0]);
    rsum = {1'b0, r53} + {{dip_pkg::SigW{1'b0}}, rinc};
    if (rsum[dip_pkg::SigW]) begin
      rfin = rsum[dip_pkg::SigW:1];
      efin = ebias + 14'sd1;
    end else begin
      rfin = rsum[dip_pkg::SigW-1:0];
      efin = ebias;
    end
    if (efin >= 14'sd2047) begin
      packed_res = {sign_q, dip_pkg::EXP_MAX, 52'h0};
    end else begin
      packed_res = {sign_q, (rfin[52] ? efin[10:0] : 11'h0), rfin[51:0]};
    end
  end

  assign rem_ge  = rem_q >= {2'b00, dvs_q};
  assign rem_sub = rem_ge ? (rem_q - {2'b00, dvs_q}) : rem_q;

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    x_d         = x_q;
    prev_d      = prev_q;
    y_d         = y_q;
    res_d       = res_q;
    have_prev_d = have_prev_q;
    recip_d     = recip_q;
    mag_d       = mag_q;
    left_d      = left_q;
    w_d         = w_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    dvs_d       = dvs_q;
    rem_d       = rem_q;
    sticky_d    = sticky_q;
    sign_d      = sign_q;
    texp_d      = texp_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          base_d = base_bits_i;
          if (exponent_i == 32'sd0) begin
            res_d   = dip_pkg::ONE_BITS;
            state_d = S_FIN;
          end else if (exponent_i[31]) begin
            mag_d   = 32'd0 - exponent_i;
            state_d = S_RSTART;
          end else begin
            mag_d   = exponent_i;
            state_d = S_START;
          end
        end
      end
      S_RSTART: begin
        recip_d = 1'b1;
        sign_d  = base_q[63];
        if (dip_pkg::is_nan(base_q)) begin
          base_d  = base_q | dip_pkg::QUIET_BIT;
          state_d = S_START;
        end else if (dip_pkg::is_zero(base_q)) begin
          base_d  = {base_q[63], dip_pkg::EXP_MAX, 52'h0};
          state_d = S_START;
        end else if (dip_pkg::is_inf(base_q)) begin
          base_d  = {base_q[63], 63'h0};
          state_d = S_START;
        end else begin
          dvs_d   = dip_pkg::sig_of(base_q);
          texp_d  = dip_pkg::exp_of(base_q);
          state_d = S_RNORM;
        end
      end
      S_RNORM: begin
        if (!dvs_q[dip_pkg::SigW-1]) begin
          dvs_d  = {dvs_q[dip_pkg::SigW-2:0], 1'b0};
          texp_d = texp_q - 14'sd1;
        end else begin
          rem_d    = {2'b00, 1'b1, 52'h0};
          w_d      = '0;
          sticky_d = 1'b0;
          cnt_d    = '0;
          state_d  = S_RDIV;
        end
      end
      S_RDIV: begin
        // quotient bits enter below the top and climb to the leading place
        w_d[PW-1:PW-dip_pkg::QuoW] = {w_q[PW-2:PW-dip_pkg::QuoW], rem_ge};
        rem_d = {rem_sub[dip_pkg::SigW:0], 1'b0};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(dip_pkg::QuoW - 1)) begin
          sticky_d = rem_sub != '0;
          texp_d   = dip_pkg::DIV_OFS - texp_q;
          state_d  = S_NORM;
        end
      end
      S_START: begin
        recip_d     = 1'b0;
        x_d         = base_q;
        have_prev_d = 1'b0;
        left_d      = mag_q - 32'd1;
        if (mag_q == 32'd1) begin
          res_d   = base_q;
          state_d = S_FIN;
        end else begin
          state_d = S_MSTART;
        end
      end
      S_MSTART: begin
        sign_d = base_q[63] ^ x_q[63];
        if (dip_pkg::is_nan(base_q)) begin
          y_d     = base_q | dip_pkg::QUIET_BIT;
          state_d = S_CHECK;
        end else if (dip_pkg::is_nan(x_q)) begin
          y_d     = x_q | dip_pkg::QUIET_BIT;
          state_d = S_CHECK;
        end else if ((dip_pkg::is_inf(base_q) && dip_pkg::is_zero(x_q)) ||
                     (dip_pkg::is_zero(base_q) && dip_pkg::is_inf(x_q))) begin
          y_d     = dip_pkg::DEFAULT_NAN;
          state_d = S_CHECK;
        end else if (dip_pkg::is_inf(base_q) || dip_pkg::is_inf(x_q)) begin
          y_d     = {base_q[63] ^ x_q[63], dip_pkg::EXP_MAX, 52'h0};
          state_d = S_CHECK;
        end else if (dip_pkg::is_zero(base_q) || dip_pkg::is_zero(x_q)) begin
          y_d     = {base_q[63] ^ x_q[63], 63'h0};
          state_d = S_CHECK;
        end else begin
          mcand_d  = {{(PW-dip_pkg::SigW){1'b0}}, dip_pkg::sig_of(base_q)};
          mplier_d = dip_pkg::sig_of(x_q);
          w_d      = '0;
          sticky_d = 1'b0;
          cnt_d    = '0;
          texp_d   = dip_pkg::exp_of(base_q) + dip_pkg::exp_of(x_q) - dip_pkg::MUL_OFS;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        if (mplier_q[0]) begin
          w_d = w_q + mcand_q;
        end
        mcand_d  = {mcand_q[PW-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[dip_pkg::SigW-1:1]};
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == 6'(dip_pkg::SigW - 1)) begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (!w_q[PW-1]) begin
          w_d    = {w_q[PW-2:0], 1'b0};
          texp_d = texp_q - 14'sd1;
        end else if (ebias < 14'sd1) begin
          state_d = S_DENORM;
        end else begin
          state_d = S_ROUND;
        end
      end
      S_DENORM: begin
        if (ebias < 14'sd1) begin
          if (w_q == '0) begin
            // everything is already in the sticky bit
            texp_d = 14'sd1 - dip_pkg::RND_OFS;
          end else begin
            sticky_d = sticky_q | w_q[0];
            w_d      = {1'b0, w_q[PW-1:1]};
            texp_d   = texp_q + 14'sd1;
          end
        end else begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        if (recip_q) begin
          base_d  = packed_res;
          state_d = S_START;
        end else begin
          y_d     = packed_res;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        left_d = left_nx;
        if (dip_pkg::is_zero(y_q) && !dip_pkg::is_nan(y_q)) begin
          res_d   = dip_pkg::POS_ZERO;
          state_d = S_FIN;
        end else if (y_q == dip_pkg::ONE_BITS) begin
          res_d   = dip_pkg::ONE_BITS;
          state_d = S_FIN;
        end else if (y_q == x_q) begin
          res_d   = y_q;
          state_d = S_FIN;
        end else if (have_prev_q && (y_q == prev_q)) begin
          // the product alternates: parity of what is left picks the phase
          res_d   = left_nx[0] ? x_q : y_q;
          state_d = S_FIN;
        end else begin
          prev_d      = x_q;
          have_prev_d = 1'b1;
          x_d         = y_q;
          if (left_nx == 32'd0) begin
            res_d   = y_q;
            state_d = S_FIN;
          end else begin
            state_d = S_MSTART;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      have_prev_q <= 1'b0;
      recip_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      have_prev_q <= have_prev_d;
      recip_q     <= recip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    x_q      <= x_d;
    prev_q   <= prev_d;
    y_q      <= y_d;
    res_q    <= res_d;
    mag_q    <= mag_d;
    left_q   <= left_d;
    w_q      <= w_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    dvs_q    <= dvs_d;
    rem_q    <= rem_d;
    sticky_q <= sticky_d;
    sign_q   <= sign_d;
    texp_q   <= texp_d;
    cnt_q    <= cnt_d;
    out_q    <= out_d;
  end

  assign in_ready_o   = state_q == S_IDLE;
  assign out_valid_o  = out_valid_q;
  assign power_bits_o = out_q;

endmodule
`default_nettype wire

### tb/sv/double_integer_power_test.sv
`default_nettype none
module double_integer_power_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandItems = 1030;
  localparam longint unsigned CycleLimit = 64'd30_000_000;
  localparam logic [63:0] NEG_ONE = 64'hBFF0_0000_0000_0000;
  localparam logic [63:0] POS_INF = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NEG_INF = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
  localparam logic [63:0] TWO_BITS = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF_BITS = 64'h3FE0_0000_0000_0000;

  typedef struct {
    logic [63:0]        base;
    logic signed [31:0] expo;
    logic [63:0]        want;
    bit                 typed;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [63:0] base_bits_i = '0;
  logic signed [31:0] exponent_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [63:0] power_bits_o;

  logic [63:0] pending_powers[$];
  stim_row_t directed_rows[$];
  int unsigned errors = 0;
  longint unsigned cycles = 0;
  int unsigned burst_left = 0;

  always #2 clk_i = ~clk_i;

  double_integer_power DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .base_bits_i, .exponent_i,
    .out_valid_o, .out_ready_i, .power_bits_o
  );

  // repeated multiply with the same early exits as the block
  function automatic logic [63:0] power_of(input logic [63:0] b, input logic [31:0] e);
    real base_r, x, y, prev;
    bit have_prev;
    logic [31:0] mag, left;
    have_prev = 1'b0;
    prev = 0.0;
    if (e == '0) return dip_pkg::ONE_BITS;
    base_r = $bitstoreal(b);
    if (e[31]) begin
      if (b[62:0] == '0) base_r = $bitstoreal({b[63], POS_INF[62:0]});
      else base_r = 1.0 / base_r;
      mag = -e;
    end else begin
      mag = e;
    end
    x = base_r;
    left = mag - 32'd1;
    while (left != 0) begin
      y = base_r * x;
      left--;
      if (y == 0.0) return dip_pkg::POS_ZERO;
      if (y == 1.0) return dip_pkg::ONE_BITS;
      if ($realtobits(y) == $realtobits(x)) return $realtobits(y);
      // the product alternates: parity of the remaining steps picks the end value
      if (have_prev && $realtobits(y) == $realtobits(prev))
        return left[0] ? $realtobits(x) : $realtobits(y);
      prev = x;
      have_prev = 1'b1;
      x = y;
    end
    return $realtobits(x);
  endfunction

  task automatic add_row(input logic [63:0] b, input logic [31:0] e,
                         input logic [63:0] w, input bit t);
    stim_row_t r;
    r.base = b;
    r.expo = e;
    r.want = w;
    r.typed = t;
    directed_rows.push_back(r);
  endtask

  task automatic send_item(input logic [63:0] b, input logic [31:0] e,
                           input logic [63:0] w, input bit t);
    base_bits_i <= b;
    exponent_i <= e;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_powers.push_back(t ? w : power_of(b, e));
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [63:0] pick_base(input bit far);
    logic [63:0] v;
    logic [10:0] bexp;
    v = {$urandom, $urandom};
    if (far) begin
      case ($urandom_range(0, 5))
        0: v[62:52] = dip_pkg::EXP_MAX;
        1: v[62:52] = '0;
        2: v[62:0] = '0;
        3: v[62:0] = dip_pkg::ONE_BITS[62:0];
        default: begin
          bexp = $urandom_range(0, 1) ? 11'($urandom_range(1130, 2046))
                                      : 11'($urandom_range(1, 920));
          v[62:52] = bexp;
        end
      endcase
    end else begin
      case ($urandom_range(0, 7))
        0, 1: v[62:52] = 11'($urandom_range(1015, 1031));
        2: v[62:52] = dip_pkg::EXP_MAX;
        3: v[62:52] = '0;
        4: v[62:0] = dip_pkg::ONE_BITS[62:0];
        default: ;
      endcase
    end
    return v;
  endfunction

  // receiver: always ready, random stalls, or long stalls, by phase
  always @(negedge clk_i) begin
    case ((cycles / 300) % 3)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 2) != 0);
      default: out_ready_i <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
    if (out_valid_o && out_ready_i) begin
      if (pending_powers.size() == 0) begin
        $display("%0t: result %h with no item pending", $time, power_bits_o);
        errors++;
      end else begin
        if (power_bits_o !== pending_powers[0]) begin
          $display("%0t: power_bits expected %h actual %h",
                   $time, pending_powers[0], power_bits_o);
          errors++;
        end
        void'(pending_powers.pop_front());
      end
    end
  end

  initial begin
    logic [63:0] b;
    logic [31:0] e;
    add_row(64'h0123_4567_89AB_CDEF, 32'sd0, dip_pkg::ONE_BITS, 1'b1);
    add_row(dip_pkg::DEFAULT_NAN, 32'sd0, dip_pkg::ONE_BITS, 1'b1);
    add_row(64'h7FF0_0000_0000_0001, 32'sd0, dip_pkg::ONE_BITS, 1'b1);
    add_row(dip_pkg::POS_ZERO, -32'sd1, POS_INF, 1'b1);
    add_row(NEG_ZERO, -32'sd1, NEG_INF, 1'b1);
    add_row(dip_pkg::POS_ZERO, 32'sd1, dip_pkg::POS_ZERO, 1'b1);
    add_row(NEG_ZERO, 32'sd1, NEG_ZERO, 1'b1);
    add_row(dip_pkg::ONE_BITS, 32'sd1, dip_pkg::ONE_BITS, 1'b1);
    add_row(NEG_ONE, 32'sd5, dip_pkg::ONE_BITS, 1'b1);
    add_row(NEG_ONE, -32'sd2, dip_pkg::ONE_BITS, 1'b1);
    add_row(NEG_ZERO, 32'sd3, dip_pkg::POS_ZERO, 1'b1);
    add_row(TWO_BITS, 32'sd10, 64'h4090_0000_0000_0000, 1'b1);
    add_row(TWO_BITS, 32'h7FFF_FFFF, POS_INF, 1'b1);
    add_row(TWO_BITS, 32'h8000_0000, dip_pkg::POS_ZERO, 1'b1);
    add_row(HALF_BITS, -32'sd3, 64'h4020_0000_0000_0000, 1'b1);
    add_row(NEG_INF, 32'sd7, '0, 1'b0);
    add_row(NEG_INF, 32'sd8, '0, 1'b0);
    add_row(64'hC000_0000_0000_0000, 32'sd1100, '0, 1'b0);
    add_row(64'h0000_0000_0000_0001, 32'sd2, '0, 1'b0);
    add_row(64'h0000_0000_0000_0001, -32'sd1, '0, 1'b0);
    add_row(64'h7FEF_FFFF_FFFF_FFFF, 32'sd2, '0, 1'b0);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 32'sd3, '0, 1'b0);
    add_row(64'h3FF0_0000_0000_0001, -32'sd7, '0, 1'b0);
    add_row(64'h7FF4_0000_0000_0000, -32'sd9, '0, 1'b0);

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].base, directed_rows[i].expo,
                directed_rows[i].want, directed_rows[i].typed);

    for (int unsigned n = 0; n < RandItems; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        b = pick_base(1'b1);
        e = $urandom;
      end else begin
        b = pick_base(1'b0);
        e = $urandom_range(0, 16);
        if ($urandom_range(0, 1)) e = -e;
      end
      send_item(b, e, '0, 1'b0);
    end
    in_valid_i <= 1'b0;

    while (pending_powers.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
hdl/dip_pkg.sv
hdl/double_integer_power.sv
tb/sv/double_integer_power_test.sv
